/* sv/shb_pkg.sv */
// Shared types and constants for the selectable string hash core.
`default_nettype none

package shb_pkg;

    typedef enum logic [2:0]
    {
        SEL_JS   = 3'd0,
        SEL_ELF  = 3'd1,
        SEL_SDBM = 3'd2,
        SEL_DJB  = 3'd3,
        SEL_DEK  = 3'd4,
        SEL_RS   = 3'd5,
        SEL_PJW  = 3'd6,
        SEL_BKDR = 3'd7
    } hash_sel_t;

    localparam logic [63:0] JS_INIT      = 64'd1315423911;
    localparam logic [63:0] DJB_INIT     = 64'd5381;
    localparam logic [31:0] RS_A_INIT    = 32'd63689;
    localparam logic [31:0] RS_B         = 32'd378551;
    localparam logic [31:0] BKDR_SEED    = 32'd131;
    localparam logic [63:0] ELF_TOP_MASK = 64'hF000_0000_0000_0000;
    localparam logic [31:0] PJW_TOP_MASK = 32'hF000_0000;
    localparam logic [31:0] PJW_LOW_MASK = 32'h0FFF_FFFF;

    // One registered transaction plus the mode captured with it
    typedef struct packed
    {
        logic [7:0]  data_byte;
        logic        start_of_string;
        logic        end_of_string;
        logic        empty_string;
        logic [31:0] string_length;
        hash_sel_t   sel;
    } item_t;

    typedef struct packed
    {
        logic [63:0] hash;
        logic [31:0] rs_mult;
        logic        emit;
    } step_t;

endpackage : shb_pkg

`default_nettype wire

/* sv/shb_step.sv */
// Single-byte hash update for all eight schemes.
`default_nettype none

module shb_step
(
    input  wire shb_pkg::item_t item,
    input  wire [63:0]          running_hash,
    input  wire [31:0]          rs_mult,
    output shb_pkg::step_t      step
);
    import shb_pkg::*;

    logic [63:0] c64;
    logic [31:0] c32;
    logic [63:0] init_val;
    logic [63:0] h;
    logic [31:0] h32;
    logic [31:0] rs_base;
    logic [63:0] elf_t;
    logic [63:0] elf_x;
    logic [31:0] pjw_p;
    logic [31:0] pjw_t;
    logic [31:0] rs_prod;
    logic [31:0] bkdr_prod;
    logic [63:0] hash_new;
    logic [31:0] mult_new;

    always_comb
    begin
        c64 = {{56{item.data_byte[7]}}, item.data_byte};
        c32 = c64[31:0];

        // Seed value; DEK takes the string length, zero on an empty string
        unique case (item.sel)
            SEL_JS:  init_val = JS_INIT;
            SEL_DJB: init_val = DJB_INIT;
            SEL_DEK: init_val = item.empty_string ? 64'd0 : {32'd0, item.string_length};
            default: init_val = 64'd0;
        endcase

        h       = item.start_of_string ? init_val : running_hash;
        rs_base = item.start_of_string ? RS_A_INIT : rs_mult;
        h32     = h[31:0];

        elf_t     = (h << 4) + c64;
        elf_x     = elf_t & ELF_TOP_MASK;
        pjw_p     = (h32 << 4) + c32;
        pjw_t     = pjw_p & PJW_TOP_MASK;
        rs_prod   = h32 * rs_base;
        bkdr_prod = h32 * BKDR_SEED;

        // a start reloads the RS multiplier whatever the scheme
        mult_new = rs_base;
        unique case (item.sel)
            SEL_JS:   hash_new = h ^ ((h << 5) + c64 + (h >> 2));
            SEL_ELF:  hash_new = (elf_t ^ (elf_x >> 24)) & ~elf_x;
            SEL_SDBM: hash_new = c64 + (h << 6) + (h << 16) - h;
            SEL_DJB:  hash_new = (h << 5) + h + c64;
            SEL_DEK:  hash_new = ((h << 5) ^ (h >> 27)) ^ c64;
            SEL_RS:
            begin
                hash_new = {32'd0, rs_prod + c32};
                mult_new = rs_base * RS_B;
            end
            SEL_PJW:
            begin
                if (pjw_t != 32'd0)
                    hash_new = {32'd0, (pjw_p ^ (pjw_t >> 24)) & PJW_LOW_MASK};
                else
                    hash_new = {32'd0, pjw_p};
            end
            default:  hash_new = {32'd0, bkdr_prod + c32};
        endcase

        if (item.empty_string)
        begin
            step.hash    = init_val;
            step.rs_mult = RS_A_INIT;
            step.emit    = 1'b1;
        end
        else
        begin
            step.hash    = hash_new;
            step.rs_mult = mult_new;
            step.emit    = item.end_of_string;
        end
    end

endmodule : shb_step

`default_nettype wire

/* sv/selectable_string_hash_core.sv */
// Top level of the selectable string hash core.
// Usage:
//   A string enters one byte per transaction on the data channel
//   (data_valid/data_ready). start_of_string reloads the scheme's seed,
//   end_of_string makes the finished hash appear on the hash channel
//   (hash_valid/hash_ready). empty_string gives the seed at once, no byte.
//   cfg_wr_en/cfg_wr_data pick the scheme; write it only while idle.
//   A byte is registered in the input register on acceptance and then
//   folded into the running hash; a finished hash is registered in the
//   output register at the same edge, and that register drives hash_valid.
//   Throughput: one byte per cycle, set by the fold loop around the
//   running hash register (RS uses two 32x32 multipliers there), while
//   the output register can take the hash of a closing byte.
//   Reset clears the running hash, the RS multiplier to 63689, the scheme
//   to JS and all valid flags. While hash_ready is low the finished hash
//   holds; bytes that do not end a string still flow, and a byte that
//   does waits in the input register until the output register frees.
`default_nettype none

module selectable_string_hash_core
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_wr_en,
    input  wire [2:0]  cfg_wr_data,
    input  wire        data_valid,
    output logic       data_ready,
    input  wire [7:0]  data_byte,
    input  wire        start_of_string,
    input  wire        end_of_string,
    input  wire        empty_string,
    input  wire [31:0] string_length,
    output logic       hash_valid,
    input  wire        hash_ready,
    output logic [63:0] hash_value
);
    import shb_pkg::*;

    hash_sel_t   sel_reg;
    item_t       item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [63:0] hash_reg;
    logic [31:0] mult_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_hash_reg;
    step_t       step;
    logic        step_fire;
    logic        accept;

    shb_step u_step
    (
        .item         (item_reg),
        .running_hash (hash_reg),
        .rs_mult      (mult_reg),
        .step         (step)
    );

    // A result-bearing transaction may only leave when the output slot frees
    assign step_fire  = item_valid_reg && (!step.emit || !out_valid_reg || hash_ready);
    assign data_ready = !item_valid_reg || step_fire;
    assign accept     = data_valid && data_ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (step_fire)
            item_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_fire && step.emit)
            out_valid_next = 1'b1;
        else if (hash_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg        <= SEL_JS;
            item_valid_reg <= 1'b0;
            hash_reg       <= 64'd0;
            mult_reg       <= RS_A_INIT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                sel_reg <= hash_sel_t'(cfg_wr_data);
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (step_fire)
            begin
                hash_reg <= step.hash;
                mult_reg <= step.rs_mult;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte       <= data_byte;
            item_reg.start_of_string <= start_of_string;
            item_reg.end_of_string   <= end_of_string;
            item_reg.empty_string    <= empty_string;
            item_reg.string_length   <= string_length;
            item_reg.sel             <= sel_reg;
        end
        if (step_fire && step.emit)
            out_hash_reg <= step.hash;
    end

    assign hash_valid = out_valid_reg;
    assign hash_value = out_hash_reg;

endmodule : selectable_string_hash_core

`default_nettype wire

/* bench/tb_selectable_string_hash_core.sv */
// Self-checking testbench for the selectable string hash core.
`timescale 1ns / 100ps

module tb_selectable_string_hash_core;
    import shb_pkg::*;

    class hash_scoreboard;
        hash_sel_t   mode;
        logic [63:0] acc;
        logic [31:0] rs_mult;
        logic [63:0] pending[$];
        int          errors;
        int          checked;

        function new();
            mode    = SEL_JS;
            acc     = 64'd0;
            rs_mult = RS_A_INIT;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_mode(hash_sel_t m);
            mode = m;
        endfunction

        function logic [63:0] seed_of(logic [31:0] len);
            case (mode)
                SEL_JS:  return JS_INIT;
                SEL_DJB: return DJB_INIT;
                SEL_DEK: return {32'd0, len};
                default: return 64'd0;
            endcase
        endfunction

        function logic [63:0] finish_value();
            if (mode == SEL_RS || mode == SEL_PJW || mode == SEL_BKDR)
                return {32'd0, acc[31:0]};
            return acc;
        endfunction

        // Fold one character, sign-extended, into the running hash
        function void fold(logic [7:0] b);
            logic [63:0] c;
            logic [63:0] h;
            logic [63:0] x;
            logic [31:0] c32;
            logic [31:0] h32;
            logic [31:0] t;
            c   = {{56{b[7]}}, b};
            h   = acc;
            c32 = c[31:0];
            h32 = h[31:0];
            case (mode)
                SEL_JS:
                    h = h ^ ((h << 5) + c + (h >> 2));
                SEL_ELF:
                begin
                    h = (h << 4) + c;
                    x = h & ELF_TOP_MASK;
                    if (x != 64'd0)
                        h = h ^ (x >> 24);
                    h = h & ~x;
                end
                SEL_SDBM:
                    h = c + (h << 6) + (h << 16) - h;
                SEL_DJB:
                    h = (h << 5) + h + c;
                SEL_DEK:
                    h = ((h << 5) ^ (h >> 27)) ^ c;
                SEL_RS:
                begin
                    h32     = h32 * rs_mult + c32;
                    rs_mult = rs_mult * RS_B;
                    h       = {32'd0, h32};
                end
                SEL_PJW:
                begin
                    h32 = (h32 << 4) + c32;
                    t   = h32 & PJW_TOP_MASK;
                    if (t != 32'd0)
                        h32 = (h32 ^ (t >> 24)) & PJW_LOW_MASK;
                    h = {32'd0, h32};
                end
                default:
                begin
                    h32 = h32 * BKDR_SEED + c32;
                    h   = {32'd0, h32};
                end
            endcase
            acc = h;
        endfunction

        function void note_input(logic [7:0] b, logic st, logic en, logic em,
                                 logic [31:0] len);
            if (em)
            begin
                acc     = seed_of(32'd0);
                rs_mult = RS_A_INIT;
                pending.push_back(finish_value());
                return;
            end
            if (st)
            begin
                acc     = seed_of(len);
                rs_mult = RS_A_INIT;
            end
            fold(b);
            if (en)
                pending.push_back(finish_value());
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(logic [63:0] got);
            logic [63:0] want;
            if (pending.size() == 0)
                report($sformatf("hash 0x%016h with none outstanding", got));
            else
            begin
                want = pending.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("hash_value 0x%016h, want 0x%016h", got, want));
            end
        endtask
    endclass

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1300;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [2:0]  cfg_wr_data     = 3'd0;
    logic        data_valid      = 1'b0;
    logic        data_ready;
    logic [7:0]  data_byte       = 8'd0;
    logic        start_of_string = 1'b0;
    logic        end_of_string   = 1'b0;
    logic        empty_string    = 1'b0;
    logic [31:0] string_length   = 32'd0;
    logic        hash_valid;
    logic        hash_ready      = 1'b0;
    logic [63:0] hash_value;

    hash_scoreboard sb;
    logic        steady = 1'b0;
    int          quiet  = 0;
    int          items_sent = 0;
    logic [7:0]  modes_seen = 8'd0;

    // generator state for the string in flight
    int          str_left  = 0;
    logic        str_first = 1'b0;
    logic [31:0] str_seed  = 32'd0;

    selectable_string_hash_core DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .data_valid      (data_valid),
        .data_ready      (data_ready),
        .data_byte       (data_byte),
        .start_of_string (start_of_string),
        .end_of_string   (end_of_string),
        .empty_string    (empty_string),
        .string_length   (string_length),
        .hash_valid      (hash_valid),
        .hash_ready      (hash_ready),
        .hash_value      (hash_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: check on each transaction, then stall at random
    always @(posedge clk)
    begin
        if (hash_valid && hash_ready)
            sb.check_result(hash_value);
        hash_ready <= steady || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        if ((data_valid && data_ready) || (hash_valid && hash_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        while (quiet < QUIET_LIMIT)
            @(posedge clk);
        $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("tb_selectable_string_hash_core: done, errors");
        $finish;
    end

    task send_item(logic [7:0] b, logic st, logic en, logic em, logic [31:0] len);
        while (!steady && $urandom_range(99) < 35)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid      <= 1'b1;
        data_byte       <= b;
        start_of_string <= st;
        end_of_string   <= en;
        empty_string    <= em;
        string_length   <= len;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        sb.note_input(b, st, en, em, len);
        items_sent++;
    endtask

    // hold off the sender until every hash is out and the fold has settled
    task drain();
        data_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_mode(hash_sel_t m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_mode(m);
        modes_seen[m] = 1'b1;
    endtask

    // Mostly well-formed strings; some empties, stray bytes, early ends, restarts
    task next_item();
        int   roll;
        logic st;
        logic en;
        if (str_left == 0)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'b1, $urandom);
                return;
            end
            if (roll < 12)
            begin
                send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0,
                          $urandom);
                return;
            end
            str_left  = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(1, 12);
            str_first = 1'b1;
            str_seed  = ($urandom_range(3) == 0) ? $urandom : str_left;
        end
        st = str_first;
        if (!str_first && $urandom_range(49) == 0)
            st = 1'b1;
        if (str_left > 1 && $urandom_range(49) == 0)
            str_left = 1;
        en = (str_left == 1);
        send_item(8'($urandom_range(255)), st, en, 1'b0, st ? str_seed : $urandom);
        str_left--;
        str_first = 1'b0;
    endtask

    initial
    begin
        int        phase;
        int        n;
        int        target;
        hash_sel_t m;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // JS from reset: stray byte, empty with all flags, one-byte and short strings
        send_item(8'h41, 1'b0, 1'b1, 1'b0, 32'h0000_0000);
        send_item(8'hFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_item(8'h80, 1'b1, 1'b0, 1'b0, 32'd3);
        send_item(8'h7F, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(8'h00, 1'b0, 1'b1, 1'b0, 32'h0000_0000);
        send_item(8'h55, 1'b0, 1'b1, 1'b0, 32'h0000_0000);

        for (int k = 1; k < 8; k++)
        begin
            drain();
            write_mode(hash_sel_t'(k));
            send_item(8'h80, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
            send_item(8'h7F, 1'b0, 1'b1, 1'b0, 32'h0000_0000);
            if (hash_sel_t'(k) == SEL_DEK)
                send_item(8'h00, 1'b0, 1'b0, 1'b1, 32'd5);
        end

        // scheme switched half way through a string
        send_item(8'hC3, 1'b1, 1'b0, 1'b0, 32'd2);
        drain();
        write_mode(SEL_RS);
        send_item(8'h3C, 1'b0, 1'b1, 1'b0, 32'd0);

        target = items_sent + RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target)
        begin
            drain();
            m = (phase < 8) ? hash_sel_t'(phase[2:0]) : hash_sel_t'($urandom_range(7));
            write_mode(m);
            steady <= (phase >= 5 && phase < 8);
            n = $urandom_range(60, 130);
            repeat (n) next_item();
            phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d hashes never arrived", sb.pending.size()));

        $display("summary: %0d transactions in, %0d hashes checked over %0d phases",
                 items_sent, sb.checked, phase);
        $display("summary: schemes selected %b, %0d mismatches", modes_seen, sb.errors);
        if (sb.errors == 0)
            $display("tb_selectable_string_hash_core: done, clean");
        else
            $display("tb_selectable_string_hash_core: done, errors");
        $finish;
    end

endmodule
